@@ rtl/core/gtr_pkg.sv @@
package gtr_pkg;

    localparam int GLYPH_COUNT = 96;
    localparam int GLYPH_ROWS  = 8;
    localparam int FONT_BYTES  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FONT_AW     = 10;
    localparam int GLYPH_W     = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] FIRST_CODE   = 8'd32;
    localparam logic [7:0] LAST_CODE    = 8'd127;
    localparam logic [7:0] PEN_STEP     = 8'd8;
    localparam logic signed [16:0] PEN_MAX = 17'sd32767;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                       op;
        logic [FONT_AW-1:0]        font_addr;
        logic [7:0]                font_byte;
        logic signed [15:0]        pen_x;
        logic signed [15:0]        pen_y;
        logic [GLYPH_W-1:0]        glyph;
        logic                      screen_sel;
        logic [15:0]               pixel_color;
    } job_t;

endpackage

@@ rtl/core/gtr_if.sv @@
interface gtr_char_if;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [9:0]         font_addr;
    logic [7:0]         font_byte;
    logic               restart_pen;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]         char_code;
    logic               screen_sel;
    logic [15:0]        pixel_color;

    modport source
    (
        output valid, mode, font_addr, font_byte, restart_pen, start_x, start_y,
               char_code, screen_sel, pixel_color,
        input  ready
    );

    modport sink
    (
        input  valid, mode, font_addr, font_byte, restart_pen, start_x, start_y,
               char_code, screen_sel, pixel_color,
        output ready
    );

endinterface

interface gtr_pix_if;

    logic        valid;
    logic        ready;
    logic [15:0] pixel_index;
    logic        target_screen;
    logic [15:0] write_color;
    logic        last_write;

    modport source
    (
        output valid, pixel_index, target_screen, write_color, last_write,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_index, target_screen, write_color, last_write,
        output ready
    );

endinterface

@@ rtl/core/gtr_front.sv @@
module gtr_front
(
    input  logic          clk,
    input  logic          rst_n,
    gtr_char_if.sink      char_ch,
    output logic          push,
    output gtr_pkg::job_t push_data,
    input  logic          full
);

    import gtr_pkg::*;

    logic signed [15:0] pen_x_reg, pen_x_next;
    logic signed [15:0] pen_y_reg, pen_y_next;
    logic signed [15:0] line_x_reg, line_x_next;
    logic               accept;
    logic signed [15:0] base_x, base_y, base_line;
    logic               is_newline;
    logic               is_printable;

    function automatic logic signed [15:0] sat_step(input logic signed [15:0] v);
        logic signed [16:0] s;
        s = 17'(v) + $signed({9'd0, PEN_STEP});
        if (s > PEN_MAX)
        begin
            s = PEN_MAX;
        end
        return 16'(s);
    endfunction

    assign char_ch.ready = !full;
    assign accept        = char_ch.valid && char_ch.ready;
    assign is_newline    = char_ch.char_code == NEWLINE_CODE;
    assign is_printable  = (char_ch.char_code >= FIRST_CODE) && (char_ch.char_code <= LAST_CODE);

    always_comb
    begin
        base_x    = char_ch.restart_pen ? char_ch.start_x : pen_x_reg;
        base_y    = char_ch.restart_pen ? char_ch.start_y : pen_y_reg;
        base_line = char_ch.restart_pen ? char_ch.start_x : line_x_reg;

        push_data.op          = char_ch.mode ? OP_DRAW : OP_LOAD;
        push_data.font_addr   = char_ch.font_addr;
        push_data.font_byte   = char_ch.font_byte;
        push_data.pen_x       = base_x;
        push_data.pen_y       = base_y;
        push_data.glyph       = is_printable ? GLYPH_W'(char_ch.char_code - FIRST_CODE)
                                             : '0;
        push_data.screen_sel  = char_ch.screen_sel;
        push_data.pixel_color = char_ch.pixel_color;

        push        = 1'b0;
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        line_x_next = line_x_reg;

        if (accept)
        begin
            if (!char_ch.mode)
            begin
                push = 32'(char_ch.font_addr) < FONT_BYTES;
            end
            else if (is_newline)
            begin
                pen_x_next  = base_line;
                pen_y_next  = sat_step(base_y);
                line_x_next = base_line;
            end
            else
            begin
                push        = 1'b1;
                pen_x_next  = sat_step(base_x);
                pen_y_next  = base_y;
                line_x_next = base_line;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            line_x_reg <= '0;
        end
        else
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            line_x_reg <= line_x_next;
        end
    end

endmodule

@@ rtl/core/gtr_queue.sv @@
module gtr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gtr_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output gtr_pkg::job_t pop_data,
    output logic          not_empty
);

    import gtr_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != QCNT_W'(QUEUE_DEPTH))
        else $error("Transaction pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("Transaction popped from an empty queue.");

endmodule

@@ rtl/core/gtr_back.sv @@
module gtr_back #(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 192
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          not_empty,
    input  gtr_pkg::job_t pop_data,
    output logic          pop,
    gtr_pix_if.source     pix_ch
);

    import gtr_pkg::*;

    localparam int XW     = $clog2(SCREEN_WIDTH);
    localparam int YW     = $clog2(SCREEN_HEIGHT);
    localparam int PROD_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_FILL = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic [3:0]         row_cnt_reg, row_cnt_next;
    logic [63:0]        mask_reg, mask_next;
    logic [5:0]         pos_reg, pos_next;
    logic [7:0]         col_ok_reg, col_ok_next;
    logic [7:0]         font_mem [FONT_BYTES];
    logic [7:0]         rd_data_reg;
    logic [FONT_AW-1:0] rd_addr;
    logic               mem_we;
    logic [2:0]         fill_row;
    logic signed [16:0] fill_y;
    logic               row_ok;
    logic [7:0]         row_bits;
    logic signed [16:0] scan_x, scan_y;
    logic [PROD_W-1:0]  lin_index;
    logic               out_free;

    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_index_reg, out_index_next;
    logic               out_screen_reg, out_screen_next;
    logic [15:0]        out_color_reg, out_color_next;
    logic               out_last_reg, out_last_next;

    assign out_free = !out_valid_reg || pix_ch.ready;
    assign rd_addr  = {job_reg.glyph, row_cnt_reg[2:0]};
    assign fill_row = 3'(row_cnt_reg - 4'd1);
    assign fill_y   = 17'(job_reg.pen_y) + $signed({14'd0, fill_row});
    assign row_ok   = (fill_y >= 17'sd0) && (fill_y < $signed(17'(SCREEN_HEIGHT)));
    assign scan_x   = 17'(job_reg.pen_x) + $signed({14'd0, pos_reg[2:0]});
    assign scan_y   = 17'(job_reg.pen_y) + $signed({14'd0, pos_reg[5:3]});
    assign lin_index = PROD_W'(scan_y[YW-1:0]) * PROD_W'(SCREEN_WIDTH)
                     + PROD_W'(scan_x[XW-1:0]);

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            row_bits[b] = rd_data_reg[7-b] & col_ok_reg[b] & row_ok;
        end
    end

    always_comb
    begin
        logic signed [16:0] cx;

        state_next      = state_reg;
        job_next        = job_reg;
        row_cnt_next    = row_cnt_reg;
        mask_next       = mask_reg;
        pos_next        = pos_reg;
        col_ok_next     = col_ok_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        out_valid_next  = pix_ch.ready ? 1'b0 : out_valid_reg;
        out_index_next  = out_index_reg;
        out_screen_next = out_screen_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    pop = 1'b1;
                    if (pop_data.op == OP_LOAD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        job_next     = pop_data;
                        row_cnt_next = '0;
                        mask_next    = '0;
                        state_next   = ST_FILL;
                        for (int c = 0; c < 8; c++)
                        begin
                            cx = 17'(pop_data.pen_x) + 17'(c);
                            col_ok_next[c] = (cx >= 17'sd0)
                                && (cx < $signed(17'(SCREEN_WIDTH)));
                        end
                    end
                end
            end
            ST_FILL:
            begin
                row_cnt_next = row_cnt_reg + 4'd1;
                if (row_cnt_reg != '0)
                begin
                    mask_next[{fill_row, 3'b000} +: 8] = row_bits;
                end
                if (row_cnt_reg == 4'd8)
                begin
                    pos_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (mask_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (!mask_reg[0] || out_free)
                begin
                    mask_next = mask_reg >> 1;
                    pos_next  = pos_reg + 6'd1;
                    if (mask_reg[0])
                    begin
                        out_valid_next  = 1'b1;
                        out_index_next  = 16'(lin_index);
                        out_screen_next = job_reg.screen_sel;
                        out_color_next  = job_reg.pixel_color;
                        out_last_next   = mask_reg[63:1] == '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_mem[pop_data.font_addr] <= pop_data.font_byte;
        end
        rd_data_reg <= font_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        row_cnt_reg    <= row_cnt_next;
        mask_reg       <= mask_next;
        pos_reg        <= pos_next;
        col_ok_reg     <= col_ok_next;
        out_index_reg  <= out_index_next;
        out_screen_reg <= out_screen_next;
        out_color_reg  <= out_color_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pix_ch.valid         = out_valid_reg;
    assign pix_ch.pixel_index   = out_index_reg;
    assign pix_ch.target_screen = out_screen_reg;
    assign pix_ch.write_color   = out_color_reg;
    assign pix_ch.last_write    = out_last_reg;

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && mask_reg == '0) |=> state_reg == ST_IDLE)
        else $error("Scan did not end on an empty glyph mask.");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && not_empty))
        else $error("Queue transaction taken outside the idle state.");

endmodule

@@ rtl/core/glyph_text_rasterizer.sv @@
// Loads with an address inside the font are queued and written to the font memory by the
// back; a newline only moves the pen in the front and is never queued. A draw leaves the
// queue and has its eight glyph rows read into a mask, then scans one glyph position per
// cycle up to the last set bit (64 at most), stalling on a set bit while the pixel output
// is busy, and then returns to idle.
// Reset clears the pen, line start, queue and output valid; the font memory is not cleared.
module glyph_text_rasterizer #(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 192
)
(
    input  logic      clk,
    input  logic      rst_n,
    gtr_char_if.sink  char_ch,
    gtr_pix_if.source pix_ch
);

    import gtr_pkg::*;

    logic push;
    job_t push_data;
    logic full;
    logic pop;
    job_t pop_data;
    logic not_empty;

    gtr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    gtr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    gtr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .pix_ch    (pix_ch)
    );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gtr_pkg::*;

    localparam int DISP_COLS     = 256;
    localparam int DISP_ROWS     = 192;
    localparam int RANDOM_ITEMS  = 216;
    localparam int LOADED_GLYPHS = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SRC_SIDE      = 0;
    localparam int SNK_SIDE      = 1;

    localparam logic [7:0] FULL_CODE  = 8'd65;
    localparam logic [7:0] EMPTY_CODE = 8'd66;
    localparam logic [7:0] CORNER_CODE = 8'd127;

    typedef struct packed
    {
        op_t                mode;
        logic [9:0]         font_addr;
        logic [7:0]         font_byte;
        logic               restart_pen;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [7:0]         char_code;
        logic               screen_sel;
        logic [15:0]        pixel_color;
    } char_item_t;

    typedef struct packed
    {
        logic [15:0] pixel_index;
        logic        target_screen;
        logic [15:0] write_color;
        logic        last_write;
    } pix_item_t;

    class glyph_write_tracker;
        logic [7:0] font_mem [FONT_BYTES];
        int         pen_x;
        int         pen_y;
        int         line_x;
        pix_item_t  expected_writes [$];
        int         errors;

        function new();
            pen_x = 0;
            pen_y = 0;
            line_x = 0;
            errors = 0;
        endfunction

        function int pen_step(input int v);
            int r;
            r = v + PEN_STEP;
            if (r > PEN_MAX)
                r = PEN_MAX;
            return r;
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task note_char(input char_item_t c);
            logic [7:0] code;
            logic [7:0] bits;
            int         base;
            int         row;
            int         col;
            int         x;
            int         y;
            pix_item_t  px;
            pix_item_t  glyph_writes [$];
            if (c.mode == OP_LOAD)
            begin
                if (c.font_addr < FONT_BYTES)
                    font_mem[c.font_addr] = c.font_byte;
            end
            else
            begin
                if (c.restart_pen)
                begin
                    pen_x = $signed(c.start_x);
                    pen_y = $signed(c.start_y);
                    line_x = pen_x;
                end
                if (c.char_code == NEWLINE_CODE)
                begin
                    pen_x = line_x;
                    pen_y = pen_step(pen_y);
                end
                else
                begin
                    code = c.char_code;
                    if (code < FIRST_CODE || code > LAST_CODE)
                        code = FIRST_CODE;
                    base = (code - FIRST_CODE) * GLYPH_ROWS;
                    for (row = 0; row < GLYPH_ROWS; row++)
                    begin
                        bits = font_mem[base + row];
                        y = pen_y + row;
                        for (col = 0; col < 8; col++)
                        begin
                            x = pen_x + col;
                            if (bits[7 - col] && x >= 0 && x < DISP_COLS && y >= 0
                                && y < DISP_ROWS)
                            begin
                                px.pixel_index = 16'(y * DISP_COLS + x);
                                px.target_screen = c.screen_sel;
                                px.write_color = c.pixel_color;
                                px.last_write = 1'b0;
                                glyph_writes.push_back(px);
                            end
                        end
                    end
                    if (glyph_writes.size() > 0)
                        glyph_writes[glyph_writes.size() - 1].last_write = 1'b1;
                    foreach (glyph_writes[i])
                        expected_writes.push_back(glyph_writes[i]);
                    pen_x = pen_step(pen_x);
                end
            end
        endtask

        task check_write(input pix_item_t got);
            pix_item_t want;
            if (expected_writes.size() == 0)
            begin
                report_mismatch($sformatf("pixel write at index %0d with none expected",
                                          got.pixel_index));
            end
            else
            begin
                want = expected_writes.pop_front();
                if (got.pixel_index !== want.pixel_index)
                    report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                              got.pixel_index, want.pixel_index));
                if (got.target_screen !== want.target_screen)
                    report_mismatch($sformatf("target_screen %0d, expected %0d at index %0d",
                                              got.target_screen, want.target_screen,
                                              want.pixel_index));
                if (got.write_color !== want.write_color)
                    report_mismatch($sformatf("write_color %h, expected %h at index %0d",
                                              got.write_color, want.write_color,
                                              want.pixel_index));
                if (got.last_write !== want.last_write)
                    report_mismatch($sformatf("last_write %0d, expected %0d at index %0d",
                                              got.last_write, want.last_write,
                                              want.pixel_index));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int unsigned cycle_count = 0;
    bit calm [2] = '{1'b0, 1'b0};
    glyph_write_tracker tracker;

    gtr_char_if char_bus ();
    gtr_pix_if  pix_bus ();

    glyph_text_rasterizer #(
        .SCREEN_WIDTH  (DISP_COLS),
        .SCREEN_HEIGHT (DISP_ROWS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_ch (char_bus),
        .pix_ch  (pix_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Each side occasionally switches into a stretch with no idle cycles at all.
    function int draw_pause(input int side);
        if ($urandom_range(0, 29) == 0)
            calm[side] = !calm[side];
        return calm[side] ? 0 : int'($urandom_range(0, 9));
    endfunction

    function char_item_t make_load(input int addr, input int data);
        char_item_t it;
        it.mode = OP_LOAD;
        it.font_addr = addr[9:0];
        it.font_byte = data[7:0];
        it.restart_pen = 1'($urandom_range(0, 1));
        it.start_x = 16'($urandom);
        it.start_y = 16'($urandom);
        it.char_code = 8'($urandom);
        it.screen_sel = 1'($urandom_range(0, 1));
        it.pixel_color = 16'($urandom);
        return it;
    endfunction

    function char_item_t make_draw(input bit restart, input int x, input int y,
                                   input logic [7:0] code);
        char_item_t it;
        it = make_load($urandom_range(0, 1023), $urandom_range(0, 255));
        it.mode = OP_DRAW;
        it.restart_pen = restart;
        it.start_x = x[15:0];
        it.start_y = y[15:0];
        it.char_code = code;
        return it;
    endfunction

    function int pick_coord(input int span);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return int'($signed(16'($urandom)));
        else if (r == 1)
            return int'($urandom_range(32752, 32767));
        else if (r == 2)
            return -32768 + int'($urandom_range(0, 15));
        return int'($urandom_range(0, span + 24)) - 12;
    endfunction

    task send_char(input char_item_t it);
        int gap;
        gap = draw_pause(SRC_SIDE);
        @(negedge clk);
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.mode <= it.mode;
        char_bus.font_addr <= it.font_addr;
        char_bus.font_byte <= it.font_byte;
        char_bus.restart_pen <= it.restart_pen;
        char_bus.start_x <= it.start_x;
        char_bus.start_y <= it.start_y;
        char_bus.char_code <= it.char_code;
        char_bus.screen_sel <= it.screen_sel;
        char_bus.pixel_color <= it.pixel_color;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        tracker.note_char(it);
    endtask

    task automatic load_glyph(input int g);
        int data;
        for (int row = 0; row < GLYPH_ROWS; row++)
        begin
            if (g == FULL_CODE - FIRST_CODE)
                data = 8'hFF;
            else if (g == EMPTY_CODE - FIRST_CODE)
                data = 8'h00;
            else if (g == CORNER_CODE - FIRST_CODE)
                data = (row == 0) ? 8'h80 : (row == GLYPH_ROWS - 1) ? 8'h01 : 8'h00;
            else
                data = $urandom_range(0, 255);
            send_char(make_load(g * GLYPH_ROWS + row, data));
        end
    endtask

    initial
    begin
        pix_item_t got;
        int        stall;
        pix_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_pause(SNK_SIDE);
            @(negedge clk);
            if (stall > 0)
            begin
                pix_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pix_bus.ready <= 1'b1;
            @(posedge clk);
            while (!pix_bus.valid)
                @(posedge clk);
            got.pixel_index = pix_bus.pixel_index;
            got.target_screen = pix_bus.target_screen;
            got.write_color = pix_bus.write_color;
            got.last_write = pix_bus.last_write;
            tracker.check_write(got);
        end
    end

    initial
    begin
        char_item_t opening [$];
        char_item_t it;
        int         kind;
        int         r;
        int         pick;
        logic [7:0] code;
        tracker = new();
        rst_n = 1'b0;
        char_bus.valid = 1'b0;
        char_bus.mode = OP_LOAD;
        char_bus.font_addr = '0;
        char_bus.font_byte = '0;
        char_bus.restart_pen = 1'b0;
        char_bus.start_x = '0;
        char_bus.start_y = '0;
        char_bus.char_code = '0;
        char_bus.screen_sel = 1'b0;
        char_bus.pixel_color = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every glyph that a draw can use is written first so that no draw reads an
        // unwritten row.
        for (int g = 0; g < LOADED_GLYPHS; g++)
            load_glyph(g);
        load_glyph(FULL_CODE - FIRST_CODE);
        load_glyph(EMPTY_CODE - FIRST_CODE);
        load_glyph(CORNER_CODE - FIRST_CODE);

        it = make_draw(1'b1, 0, 0, FULL_CODE);
        it.screen_sel = 1'b0;
        it.pixel_color = 16'h0000;
        opening.push_back(it);
        it = make_draw(1'b1, DISP_COLS - 8, DISP_ROWS - 8, FULL_CODE);
        it.screen_sel = 1'b1;
        it.pixel_color = 16'hFFFF;
        opening.push_back(it);
        opening.push_back(make_draw(1'b1, -4, -4, FULL_CODE));
        opening.push_back(make_draw(1'b0, 0, 0, FULL_CODE));
        opening.push_back(make_draw(1'b1, DISP_COLS - 4, DISP_ROWS - 4, FULL_CODE));
        opening.push_back(make_draw(1'b1, 100, 50, EMPTY_CODE));
        opening.push_back(make_draw(1'b0, 0, 0, CORNER_CODE));
        opening.push_back(make_draw(1'b0, 0, 0, FIRST_CODE));
        opening.push_back(make_draw(1'b0, 0, 0, 8'd0));
        opening.push_back(make_draw(1'b0, 0, 0, 8'd31));
        opening.push_back(make_draw(1'b0, 0, 0, 8'd128));
        opening.push_back(make_draw(1'b0, 0, 0, 8'd255));
        opening.push_back(make_draw(1'b0, 0, 0, NEWLINE_CODE));
        opening.push_back(make_draw(1'b0, 0, 0, FULL_CODE));
        opening.push_back(make_draw(1'b1, 10, 20, NEWLINE_CODE));
        opening.push_back(make_draw(1'b1, -8, 0, FULL_CODE));
        opening.push_back(make_draw(1'b1, 32767, 32767, FULL_CODE));
        opening.push_back(make_draw(1'b0, 0, 0, FULL_CODE));
        opening.push_back(make_draw(1'b0, 0, 0, NEWLINE_CODE));
        opening.push_back(make_draw(1'b1, -32768, -32768, FULL_CODE));
        opening.push_back(make_load(1023, 8'hFF));
        opening.push_back(make_load(FONT_BYTES, 8'hAA));
        opening.push_back(make_load((FULL_CODE - FIRST_CODE) * GLYPH_ROWS + 3, 8'h5A));
        opening.push_back(make_draw(1'b1, 16, 16, FULL_CODE));
        opening.push_back(make_draw(1'b1, 0, DISP_ROWS, FULL_CODE));
        opening.push_back(make_draw(1'b1, DISP_COLS, 0, FULL_CODE));
        foreach (opening[i])
            send_char(opening[i]);

        // Mostly on-screen text runs with frequent pen restarts, mixed with font rewrites.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                if ($urandom_range(0, 6) == 0)
                    it = make_load($urandom_range(FONT_BYTES, 1023), $urandom_range(0, 255));
                else
                    it = make_load($urandom_range(0, FONT_BYTES - 1), $urandom_range(0, 255));
            end
            else
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    code = NEWLINE_CODE;
                else if (r == 1)
                    code = 8'($urandom_range(0, 31));
                else if (r == 2)
                    code = 8'($urandom_range(128, 255));
                else
                begin
                    pick = $urandom_range(0, LOADED_GLYPHS + 2);
                    if (pick < LOADED_GLYPHS)
                        code = FIRST_CODE + 8'(pick);
                    else if (pick == LOADED_GLYPHS)
                        code = FULL_CODE;
                    else if (pick == LOADED_GLYPHS + 1)
                        code = EMPTY_CODE;
                    else
                        code = CORNER_CODE;
                end
                it = make_draw($urandom_range(0, 3) == 0, pick_coord(DISP_COLS),
                               pick_coord(DISP_ROWS), code);
            end
            send_char(it);
        end
        @(negedge clk);
        char_bus.valid <= 1'b0;

        while (tracker.expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.expected_writes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/gtr_pkg.sv
rtl/core/gtr_if.sv
rtl/core/gtr_front.sv
rtl/core/gtr_queue.sv
rtl/core/gtr_back.sv
rtl/core/glyph_text_rasterizer.sv
tb/sv/testbench.sv
